/* rtl/core/bf5_pkg.sv */
// Shared types, tables and helpers for the 5x5 bilateral filter.
// No dependencies.
`default_nettype none
package bf5_pkg;

    typedef enum logic [4:0] {
        S_IDLE, S_IN, S_WR, S_LIN, S_CMP, S_CEN, S_POS, S_ADR, S_REQ, S_RD,
        S_SQ, S_MT, S_WT, S_ACC, S_DINIT, S_DSTEP, S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic in_step;
        logic write;
        logic lin;
        logic cen_start;
        logic pos;
        logic cen;
        logic adr;
        logic req;
        logic rd;
        logic sq;
        logic mul_t;
        logic wt;
        logic acc;
        logic dinit;
        logic dstep;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic drop;
        logic emit;
        logic last_tap;
        logic div_last;
        logic out_free;
    } t_status;

    localparam logic [3:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [3:0] REG_FRAME_HEIGHT = 4'd1;
    localparam logic [3:0] REG_RANGE_SCALE  = 4'd2;
    localparam logic [3:0] REG_SPATIAL_D1   = 4'd3;
    localparam logic [3:0] REG_SPATIAL_D2   = 4'd4;
    localparam logic [3:0] REG_SPATIAL_D4   = 4'd5;
    localparam logic [3:0] REG_SPATIAL_D5   = 4'd6;
    localparam logic [3:0] REG_SPATIAL_D8   = 4'd7;

    localparam logic [16:0] FRAC [64] = '{
        17'd65536, 17'd64830, 17'd64132, 17'd63441, 17'd62757, 17'd62081, 17'd61413,
        17'd60751, 17'd60097, 17'd59449, 17'd58809, 17'd58176, 17'd57549, 17'd56929,
        17'd56316, 17'd55709, 17'd55109, 17'd54515, 17'd53928, 17'd53347, 17'd52773,
        17'd52204, 17'd51642, 17'd51085, 17'd50535, 17'd49991, 17'd49452, 17'd48920,
        17'd48393, 17'd47871, 17'd47356, 17'd46846, 17'd46341, 17'd45842, 17'd45348,
        17'd44859, 17'd44376, 17'd43898, 17'd43425, 17'd42958, 17'd42495, 17'd42037,
        17'd41584, 17'd41136, 17'd40693, 17'd40255, 17'd39821, 17'd39392, 17'd38968,
        17'd38548, 17'd38133, 17'd37722, 17'd37316, 17'd36914, 17'd36516, 17'd36123,
        17'd35734, 17'd35349, 17'd34968, 17'd34591, 17'd34219, 17'd33850, 17'd33486,
        17'd33125
    };

    // row mod 6 by reciprocal multiply, exact below 8192
    function automatic logic [2:0] bf5_mod6(input logic [12:0] r);
        logic [31:0] q;
        logic [31:0] m;
        q = (32'(r) * 32'd2731) >> 14;
        m = 32'(r) - q * 32'd6;
        return m[2:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/core/bilateral_filter_5x5_top.sv */
// Item without a result: accepted, stepped in and, unless dropped, written and compared.
// Item with a result: the shared tap unit does the centre fetch, then each of
// the 25 taps in turn, then the divider.
// One item in flight; the result register frees the input while it waits.
// Synchronous active-low reset clears counters and valid flags and loads the default config.
`default_nettype none
module bilateral_filter_5x5_top
    import bf5_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // pixel_in
    input  wire logic        s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,   // pixel_out
    output logic             m_axis_tlast
);
    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = i_rst_n;

    bf5_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    bf5_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_func      (s_axis_tuser),
        .i_pix       (s_axis_tdata),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_pix     (m_axis_tdata),
        .o_m_last    (m_axis_tlast),
        .i_cmd       (cmd),
        .o_status    (status)
    );
endmodule
`default_nettype wire

/* rtl/core/bf5_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module bf5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 6144
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* rtl/core/bf5_ctrl.sv */
// Sequencer for the 5x5 bilateral filter: input step, 25 taps, division.
// Depends on bf5_pkg.
`default_nettype none
module bf5_ctrl
    import bf5_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_valid,
    output logic         o_s_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);
    t_state r_state, n_state;
    logic   r_cen, n_cen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cen   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cen   <= n_cen;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cen     = r_cen;
        o_cmd     = '0;
        o_cmd.cen = r_cen;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = i_rst_n;
                if (i_s_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_IN;
                end
            end
            S_IN: begin
                if (i_status.drop) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.in_step = 1'b1;
                    n_state       = S_WR;
                end
            end
            S_WR: begin
                o_cmd.write = 1'b1;
                n_state     = S_LIN;
            end
            S_LIN: begin
                o_cmd.lin = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                n_state = i_status.emit ? S_CEN : S_IDLE;
            end
            S_CEN: begin
                o_cmd.cen_start = 1'b1;
                n_cen           = 1'b1;
                n_state         = S_POS;
            end
            S_POS: begin
                o_cmd.pos = 1'b1;
                n_state   = S_ADR;
            end
            S_ADR: begin
                o_cmd.adr = 1'b1;
                n_state   = S_REQ;
            end
            S_REQ: begin
                o_cmd.req = 1'b1;
                n_state   = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_cen    = 1'b0;
                n_state  = r_cen ? S_POS : S_SQ;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_MT;
            end
            S_MT: begin
                o_cmd.mul_t = 1'b1;
                n_state     = S_WT;
            end
            S_WT: begin
                o_cmd.wt = 1'b1;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_status.last_tap ? S_DINIT : S_POS;
            end
            S_DINIT: begin
                o_cmd.dinit = 1'b1;
                n_state     = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.dstep = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_cen_only_before_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cen |-> (r_state == S_POS || r_state == S_ADR || r_state == S_REQ
                   || r_state == S_RD))
        else $error("centre flag outside centre fetch");
    a_div_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSTEP && i_status.div_last) |=> r_state == S_OUT)
        else $error("division end lost");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_IN)
        else $error("accepted item not stepped");
endmodule
`default_nettype wire

/* rtl/core/bf5_dp.sv */
// Datapath of the 5x5 bilateral filter: config registers, counters, tap maths,
// divider and output register. Depends on bf5_pkg and bf5_ram.
`default_nettype none
module bf5_dp
    import bf5_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_pix,
    input  wire logic        i_m_ready,
    output logic             o_m_valid,
    output logic      [7:0]  o_m_pix,
    output logic             o_m_last,
    input  wire t_cmd        i_cmd,
    output t_status          o_status
);
    localparam int DEPTH = 6 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = HW + 1;
    localparam int ORW   = $clog2(MAX_HEIGHT);
    localparam int LW    = RW + WW + 1;

    logic [10:0] r_fw, r_fh;
    logic [23:0] r_scale;
    logic [15:0] r_s1, r_s2, r_s4, r_s5, r_s8;

    logic [12:0]   w13, h13;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    logic          r_func;
    logic [7:0]    r_pix;
    logic [CW-1:0] r_in_col, r_out_col;
    logic [RW-1:0] r_in_row;
    logic [ORW-1:0] r_out_row;

    logic          r_wen;
    logic [AW-1:0] r_waddr, r_raddr;
    logic [7:0]    r_wpix, ram_q;
    logic [LW-1:0] r_lin_in, r_lin_out;

    logic [ORW-1:0] r_cr, r_tr;
    logic [CW-1:0]  r_cc, r_tc;
    logic [2:0]     r_dr, r_dc, dr, dc;
    logic [7:0]     r_cen, r_p, r_diff;
    logic [15:0]    r_sq;
    logic [39:0]    r_t;
    logic [33:0]    r_w;
    logic [45:0]    r_num;
    logic [36:0]    r_den;
    logic [46:0]    r_rem, dsh;
    logic [37:0]    r_dv;
    logic [3:0]     r_k;
    logic [8:0]     r_q;
    logic           r_last;

    logic           in_lt_h, in_wrap, out_wrap, out_end;
    logic signed [16:0] sr, sc;
    logic [16:0]    rng, sp;
    logic [1:0]     ad, bd;
    logic [3:0]     tap_dist;

    assign w13   = {2'b0, r_fw} < 13'd3 ? 13'd3
                 : ({2'b0, r_fw} > 13'(MAX_WIDTH) ? 13'(MAX_WIDTH) : {2'b0, r_fw});
    assign h13   = {2'b0, r_fh} < 13'd3 ? 13'd3
                 : ({2'b0, r_fh} > 13'(MAX_HEIGHT) ? 13'(MAX_HEIGHT) : {2'b0, r_fh});
    assign w_eff = w13[WW-1:0];
    assign h_eff = h13[HW-1:0];

    assign in_lt_h  = 16'(r_in_row) < 16'(h_eff);
    assign in_wrap  = 16'(r_in_col) + 16'd1 >= 16'(w_eff);
    assign out_wrap = 16'(r_out_col) + 16'd1 >= 16'(w_eff);
    assign out_end  = 16'(r_out_row) + 16'd1 >= 16'(h_eff);

    assign dr = i_cmd.cen ? 3'd2 : r_dr;
    assign dc = i_cmd.cen ? 3'd2 : r_dc;
    assign sr = $signed(17'(r_cr)) + $signed(17'(dr)) - 17'sd2;
    assign sc = $signed(17'(r_cc)) + $signed(17'(dc)) - 17'sd2;

    assign ad       = r_dr >= 3'd2 ? 2'(r_dr - 3'd2) : 2'(3'd2 - r_dr);
    assign bd       = r_dc >= 3'd2 ? 2'(r_dc - 3'd2) : 2'(3'd2 - r_dc);
    assign tap_dist = 4'(ad * ad) + 4'(bd * bd);
    always_comb begin
        case (tap_dist)
            4'd0:    sp = 17'd65536;
            4'd1:    sp = 17'(r_s1);
            4'd2:    sp = 17'(r_s2);
            4'd4:    sp = 17'(r_s4);
            4'd5:    sp = 17'(r_s5);
            4'd8:    sp = 17'(r_s8);
            default: sp = 17'd0;
        endcase
    end
    assign rng = r_t[39:24] >= 16'd16 ? 17'd0 : FRAC[r_t[23:18]] >> r_t[27:24];
    assign dsh = 47'(r_dv) << r_k;

    assign o_status.drop     = in_lt_h && r_func;
    assign o_status.emit     = (LW + 1)'(r_lin_in) >= (LW + 1)'(r_lin_out)
                             + (LW + 1)'({w_eff, 1'b0}) + (LW + 1)'(3);
    assign o_status.last_tap = r_dr == 3'd4 && r_dc == 3'd4;
    assign o_status.div_last = r_k == 4'd0;
    assign o_status.out_free = !o_m_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw    <= 11'd768;
            r_fh    <= 11'd512;
            r_scale <= 24'd120910;
            r_s1    <= 16'd39750;
            r_s2    <= 16'd24109;
            r_s4    <= 16'd8869;
            r_s5    <= 16'd5380;
            r_s8    <= 16'd1200;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_fw    <= i_cfg_data[10:0];
                REG_FRAME_HEIGHT: r_fh    <= i_cfg_data[10:0];
                REG_RANGE_SCALE:  r_scale <= i_cfg_data;
                REG_SPATIAL_D1:   r_s1    <= i_cfg_data[15:0];
                REG_SPATIAL_D2:   r_s2    <= i_cfg_data[15:0];
                REG_SPATIAL_D4:   r_s4    <= i_cfg_data[15:0];
                REG_SPATIAL_D5:   r_s5    <= i_cfg_data[15:0];
                REG_SPATIAL_D8:   r_s8    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cmd.in_step) begin
            if (in_wrap) begin
                r_in_col <= '0;
                r_in_row <= r_in_row + RW'(1);
            end else begin
                r_in_col <= r_in_col + CW'(1);
            end
        end else if (i_cmd.cen_start) begin
            if (out_wrap && out_end) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (out_wrap) begin
                r_out_col <= '0;
                r_out_row <= r_out_row + ORW'(1);
            end else begin
                r_out_col <= r_out_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_func;
            r_pix  <= i_pix;
        end
        if (i_cmd.in_step) begin
            r_wen   <= in_lt_h;
            r_wpix  <= r_pix;
            r_waddr <= AW'(32'(bf5_mod6(13'(r_in_row[HW-1:0]))) * MAX_WIDTH
                           + 32'(r_in_col));
        end
        if (i_cmd.lin) begin
            r_lin_in  <= LW'(r_in_row * w_eff) + LW'(r_in_col);
            r_lin_out <= LW'(r_out_row * w_eff) + LW'(r_out_col);
        end
        if (i_cmd.cen_start) begin
            r_cr   <= 16'(r_out_row) < 16'(h_eff) ? r_out_row : ORW'(h_eff - HW'(1));
            r_cc   <= 16'(r_out_col) < 16'(w_eff) ? r_out_col : CW'(w_eff - WW'(1));
            r_last <= out_wrap && out_end;
            r_num  <= '0;
            r_den  <= '0;
            r_dr   <= '0;
            r_dc   <= '0;
        end
        if (i_cmd.pos) begin
            if (sr < 17'sd0) begin
                r_tr <= '0;
            end else if (sr > $signed(17'(h_eff)) - 17'sd1) begin
                r_tr <= ORW'(h_eff - HW'(1));
            end else begin
                r_tr <= ORW'(unsigned'(sr));
            end
            if (sc < 17'sd0) begin
                r_tc <= '0;
            end else if (sc > $signed(17'(w_eff)) - 17'sd1) begin
                r_tc <= CW'(w_eff - WW'(1));
            end else begin
                r_tc <= CW'(unsigned'(sc));
            end
        end
        if (i_cmd.adr) begin
            r_raddr <= AW'(32'(bf5_mod6(13'(r_tr))) * MAX_WIDTH + 32'(r_tc));
        end
        if (i_cmd.rd) begin
            if (i_cmd.cen) begin
                r_cen <= ram_q;
            end else begin
                r_p    <= ram_q;
                r_diff <= r_cen > ram_q ? r_cen - ram_q : ram_q - r_cen;
            end
        end
        if (i_cmd.sq) begin
            r_sq <= 16'(r_diff) * 16'(r_diff);
        end
        if (i_cmd.mul_t) begin
            r_t <= 40'(r_sq) * 40'(r_scale);
        end
        if (i_cmd.wt) begin
            r_w <= 34'(sp) * 34'(rng);
        end
        if (i_cmd.acc) begin
            r_num <= r_num + 46'(r_w) * 46'(r_p);
            r_den <= r_den + 37'(r_w);
            if (r_dc == 3'd4) begin
                r_dc <= '0;
                r_dr <= r_dr + 3'd1;
            end else begin
                r_dc <= r_dc + 3'd1;
            end
        end
        if (i_cmd.dinit) begin
            r_rem <= {r_num, 1'b0} + 47'(r_den);
            r_dv  <= {r_den, 1'b0};
            r_k   <= 4'd8;
            r_q   <= '0;
        end
        if (i_cmd.dstep) begin
            if (r_rem >= dsh) begin
                r_rem    <= r_rem - dsh;
                r_q[r_k] <= 1'b1;
            end
            r_k <= r_k - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_valid <= 1'b0;
        end else if (i_cmd.load) begin
            o_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            o_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_m_pix  <= r_q > 9'd255 ? 8'hFF : r_q[7:0];
            o_m_last <= r_last;
        end
    end

    bf5_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write && r_wen),
        .i_waddr (r_waddr),
        .i_wdata (r_wpix),
        .i_re    (i_cmd.req),
        .i_raddr (r_raddr),
        .o_rdata (ram_q)
    );

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.write && r_wen) |-> 32'(r_waddr) < 32'(DEPTH))
        else $error("store write out of range");
    a_tap_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.adr |-> (16'(r_tr) < 16'(h_eff) && 16'(r_tc) < 16'(w_eff)))
        else $error("tap outside frame");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!o_m_valid || i_m_ready))
        else $error("result overwritten");
endmodule
`default_nettype wire
